>>> design/gjr_pkg.sv
package gjr_pkg;

  localparam int MaxDim = 8;
  localparam int DimW = 3;
  localparam int AddrW = 6;
  localparam int CntW = 7;
  localparam int QDepth = 4;
  localparam int QPtrW = 2;

  localparam logic [1:0] RegRows = 2'd0;
  localparam logic [1:0] RegCols = 2'd1;
  localparam logic [1:0] RegThr = 2'd2;

  typedef struct packed {
    logic [31:0] value;
    logic [AddrW-1:0] addr;
    logic store;
    logic last;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SRCH,
    BK_SRCHW,
    BK_SWAPR,
    BK_SWAPW,
    BK_DIVR,
    BK_DIVW,
    BK_DIVRUN,
    BK_FACR,
    BK_ELR,
    BK_ELW,
    BK_EMIT,
    BK_EMITW
  } bk_state_e;

  function automatic logic [DimW:0] clamp_dim(input logic [3:0] v);
    if (v == 4'd0) return (DimW+1)'(1);
    if (v > 4'(MaxDim)) return (DimW+1)'(MaxDim);
    return v[DimW:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7fffffff) return 32'h7fffffff;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

endpackage

>>> design/gauss_jordan_reduce_unit.sv
// Channel  | Handshake          | Payload
// input    | push / full        | element_value_i, is_last_i
// result   | empty / pop        | result_value_o, row_index_o, col_index_o,
//          |                    | singular_o, last_out_o
// config   | psel/penable/pwrite| paddr, pwdata, prdata
// Loading takes one element per cycle through a four-entry command queue
// unless it is full. Each pivot column costs a search over the rows, a row
// swap if a larger pivot lies below, and a bit-serial division per column
// from the pivot on. Elimination reads a pivot-row and a target-row element,
// then writes the result; a stalled pop on the result side holds the back end.
// Reset is asynchronous and clears control state only.
module gauss_jordan_reduce_unit
  import gjr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  logic [31:0] element_value_i,
  input  logic is_last_i,
  output logic empty,
  input  logic pop,
  output logic [31:0] result_value_o,
  output logic [2:0] row_index_o,
  output logic [2:0] col_index_o,
  output logic singular_o,
  output logic last_out_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic [3:0] rows_q, cols_q;
  logic [15:0] thr_q;
  logic [DimW:0] rows, cols;
  logic qv, qp;
  cmd_t qc;

  assign pready = 1'b1;
  assign rows = clamp_dim(rows_q);
  assign cols = clamp_dim(cols_q);

  always_comb begin
    unique case (paddr[3:2])
      RegRows: prdata = {28'd0, rows_q};
      RegCols: prdata = {28'd0, cols_q};
      RegThr:  prdata = {16'd0, thr_q};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 4'd8;
      cols_q <= 4'd8;
      thr_q <= 16'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegRows: rows_q <= pwdata[3:0];
        RegCols: cols_q <= pwdata[3:0];
        RegThr:  thr_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  gjr_front u_front (
    .clk_i, .rst_ni, .push, .full, .element_value_i, .is_last_i,
    .rows_i(rows), .cols_i(cols), .q_valid_o(qv), .q_cmd_o(qc), .q_pop_i(qp)
  );

  gjr_back u_back (
    .clk_i, .rst_ni, .rows_i(rows), .cols_i(cols), .thr_i(thr_q),
    .q_valid_i(qv), .q_cmd_i(qc), .q_pop_o(qp), .empty, .pop,
    .result_value_o, .row_index_o, .col_index_o, .singular_o, .last_out_o
  );

endmodule

>>> design/gjr_front.sv
module gjr_front
  import gjr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  logic [31:0] element_value_i,
  input  logic is_last_i,
  input  logic [DimW:0] rows_i,
  input  logic [DimW:0] cols_i,
  output logic q_valid_o,
  output cmd_t q_cmd_o,
  input  logic q_pop_i
);

  cmd_t q_mem [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0] cnt_q;
  logic [CntW-1:0] ld_q, ld_d;
  logic [DimW-1:0] r_q, r_d, c_q, c_d;
  logic [CntW-1:0] total;
  logic acc, deq;
  cmd_t cmd;

  assign total = CntW'(rows_i * cols_i);
  assign full = (cnt_q == (QPtrW+1)'(QDepth));
  assign acc = push && !full;
  assign deq = q_pop_i && (cnt_q != '0);
  assign q_valid_o = (cnt_q != '0);
  assign q_cmd_o = q_mem[rp_q];

  always_comb begin
    cmd.value = element_value_i;
    cmd.addr = {r_q, c_q};
    cmd.store = (ld_q < total);
    cmd.last = is_last_i;
    ld_d = ld_q;
    r_d = r_q;
    c_d = c_q;
    if (is_last_i) begin
      ld_d = '0;
      r_d = '0;
      c_d = '0;
    end else if (cmd.store) begin
      ld_d = ld_q + 1'b1;
      if ({1'b0, c_q} == cols_i - 1'b1) begin
        c_d = '0;
        r_d = r_q + 1'b1;
      end else begin
        c_d = c_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) q_mem[wp_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
      ld_q <= '0;
      r_q <= '0;
      c_q <= '0;
    end else begin
      if (acc) begin
        wp_q <= wp_q + 1'b1;
        ld_q <= ld_d;
        r_q <= r_d;
        c_q <= c_d;
      end
      if (deq) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(acc) - (QPtrW+1)'(deq);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (QPtrW+1)'(QDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc && is_last_i |=> ld_q == '0)
    else $error("load count not cleared after last");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ld_q <= total || !$stable(total))
    else $error("load count beyond matrix size");

endmodule

>>> design/gjr_div.sv
module gjr_div
  import gjr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic busy_o,
  output logic [31:0] quo_o
);

  logic [47:0] nmag_q, qt_q;
  logic [32:0] rem_q, dmag_q;
  logic [5:0] cnt_q;
  logic neg_q, run_q;
  logic [33:0] trial;
  logic signed [63:0] sq;
  logic [31:0] nm, dm;

  assign nm = num_i[31] ? 32'(-num_i) : num_i;
  assign dm = den_i[31] ? 32'(-den_i) : den_i;
  assign trial = {rem_q, nmag_q[47]} - {1'b0, dmag_q};
  assign busy_o = run_q;
  assign sq = neg_q ? -$signed({16'd0, qt_q}) : $signed({16'd0, qt_q});
  assign quo_o = sat32(sq);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nmag_q <= {nm, 16'd0};
      dmag_q <= {1'b0, dm};
      rem_q <= '0;
      qt_q <= '0;
      neg_q <= num_i[31] ^ den_i[31];
      cnt_q <= 6'd48;
    end else if (run_q) begin
      nmag_q <= {nmag_q[46:0], 1'b0};
      if (!trial[33]) begin
        rem_q <= trial[32:0];
        qt_q <= {qt_q[46:0], 1'b1};
      end else begin
        rem_q <= {rem_q[31:0], nmag_q[47]};
        qt_q <= {qt_q[46:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) run_q <= 1'b0;
    else if (start_i) run_q <= 1'b1;
    else if (run_q && cnt_q == 6'd1) run_q <= 1'b0;
  end

endmodule

>>> design/gjr_back.sv
module gjr_back
  import gjr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [DimW:0] rows_i,
  input  logic [DimW:0] cols_i,
  input  logic [15:0] thr_i,
  input  logic q_valid_i,
  input  cmd_t q_cmd_i,
  output logic q_pop_o,
  output logic empty,
  input  logic pop,
  output logic [31:0] result_value_o,
  output logic [2:0] row_index_o,
  output logic [2:0] col_index_o,
  output logic singular_o,
  output logic last_out_o
);

  logic [31:0] mem [MaxDim*MaxDim];
  logic [31:0] rd_q;
  logic [AddrW-1:0] ra;
  logic we;
  logic [AddrW-1:0] wa;
  logic [31:0] wd;

  bk_state_e st_q, st_d;
  logic [DimW-1:0] k_q, k_d, i_q, i_d, j_q, j_d, best_q, best_d;
  logic [32:0] bmag_q, bmag_d;
  logic [31:0] piv_q, piv_d, fac_q, fac_d, tmp_q, tmp_d, kv_q, kv_d;
  logic [1:0] ph_q, ph_d;
  logic sing_q, sing_d;
  logic ov_q, ov_d;
  logic [DimW:0] lim;
  logic dstart, dbusy;
  logic [31:0] dquo;
  logic [32:0] m;
  logic signed [63:0] prod_q, prod_d;

  logic [31:0] ob_val_q;
  logic [2:0] ob_r_q, ob_c_q;
  logic ob_s_q, ob_l_q;

  gjr_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(rd_q), .den_i(piv_q),
    .busy_o(dbusy), .quo_o(dquo)
  );

  assign lim = (rows_i < cols_i) ? rows_i : cols_i;
  assign m = rd_q[31] ? 33'(-{1'b1, rd_q}) : {1'b0, rd_q};
  assign empty = !ov_q;
  assign result_value_o = ob_val_q;
  assign row_index_o = ob_r_q;
  assign col_index_o = ob_c_q;
  assign singular_o = ob_s_q;
  assign last_out_o = ob_l_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_comb begin
    st_d = st_q; k_d = k_q; i_d = i_q; j_d = j_q; best_d = best_q;
    bmag_d = bmag_q; piv_d = piv_q; fac_d = fac_q; tmp_d = tmp_q; kv_d = kv_q;
    ph_d = ph_q; sing_d = sing_q; ov_d = ov_q; prod_d = prod_q;
    ra = '0; we = 1'b0; wa = '0; wd = '0; q_pop_o = 1'b0; dstart = 1'b0;
    if (ov_q && pop) ov_d = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          we = q_cmd_i.store;
          wa = q_cmd_i.addr;
          wd = q_cmd_i.value;
          if (q_cmd_i.last) begin
            k_d = '0; sing_d = 1'b0;
            if (lim == '0) st_d = BK_EMIT;
            else begin
              i_d = '0; ra = '0; st_d = BK_SRCH;
            end
          end
        end
      end
      BK_SRCH: begin
        // Issue the read of row k column k and start the search at i=k.
        i_d = k_q; ra = {k_q, k_q}; st_d = BK_SRCHW; bmag_d = '0; best_d = k_q;
      end
      BK_SRCHW: begin
        if (i_q == k_q || m > bmag_q) begin
          bmag_d = m; best_d = i_q;
        end
        if ({1'b0, i_q} == rows_i - 1'b1) begin
          i_d = '0;
          if ((i_q == k_q || m > bmag_q ? m : bmag_q) == '0 ||
              (i_q == k_q || m > bmag_q ? m : bmag_q) < {17'd0, thr_i}) begin
            sing_d = 1'b1; i_d = '0; j_d = '0; st_d = BK_EMIT;
          end else begin
            j_d = '0; ph_d = '0; st_d = BK_SWAPR;
          end
        end else begin
          i_d = i_q + 1'b1; ra = {i_q + 1'b1, k_q};
        end
      end
      BK_SWAPR: begin
        if (best_q == k_q) begin
          j_d = k_q; ra = {k_q, k_q}; ph_d = '0; st_d = BK_DIVR;
        end else begin
          ra = {k_q, j_q}; st_d = BK_SWAPW; ph_d = '0;
        end
      end
      BK_SWAPW: begin
        unique case (ph_q)
          2'd0: begin
            ra = {best_q, j_q}; tmp_d = rd_q; ph_d = 2'd1;
          end
          2'd1: begin
            we = 1'b1; wa = {k_q, j_q}; wd = rd_q; ph_d = 2'd2;
          end
          default: begin
            we = 1'b1; wa = {best_q, j_q}; wd = tmp_q; ph_d = 2'd0;
            if (j_q == 3'(MaxDim-1)) begin
              j_d = k_q; ra = {k_q, k_q}; st_d = BK_DIVR;
            end else begin
              j_d = j_q + 1'b1; st_d = BK_SWAPR;
            end
          end
        endcase
      end
      BK_DIVR: begin
        ra = {k_q, j_q}; st_d = BK_DIVW;
        if (j_q == k_q) ph_d = 2'd0;
      end
      BK_DIVW: begin
        ra = {k_q, j_q};
        if (j_q == k_q) piv_d = rd_q;
        st_d = BK_DIVRUN; ph_d = 2'd0;
      end
      BK_DIVRUN: begin
        if (ph_q == 2'd0) begin
          dstart = 1'b1; ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          ph_d = 2'd2;
        end else if (!dbusy) begin
          we = 1'b1; wa = {k_q, j_q}; wd = dquo;
          if ({1'b0, j_q} == cols_i - 1'b1) begin
            i_d = '0; st_d = BK_FACR; ph_d = '0;
          end else begin
            j_d = j_q + 1'b1; st_d = BK_DIVR;
          end
        end
      end
      BK_FACR: begin
        if (i_q == k_q) begin
          if ({1'b0, i_q} == rows_i - 1'b1) begin
            if ({1'b0, k_q} == lim - 1'b1) begin
              i_d = '0; j_d = '0; st_d = BK_EMIT;
            end else begin
              k_d = k_q + 1'b1; st_d = BK_SRCH;
            end
          end else i_d = i_q + 1'b1;
        end else begin
          unique case (ph_q)
            2'd0: begin ra = {i_q, k_q}; ph_d = 2'd1; end
            2'd1: begin ra = {i_q, k_q}; ph_d = 2'd2; end
            default: begin
              fac_d = rd_q; j_d = k_q; ph_d = '0; st_d = BK_ELR;
            end
          endcase
        end
      end
      BK_ELR: begin
        unique case (ph_q)
          2'd0: begin ra = {k_q, j_q}; ph_d = 2'd1; end
          2'd1: begin ra = {i_q, j_q}; kv_d = rd_q; ph_d = 2'd2; end
          default: begin
            prod_d = $signed(kv_q) * $signed(fac_q);
            tmp_d = rd_q; ph_d = '0; st_d = BK_ELW;
          end
        endcase
      end
      BK_ELW: begin
        we = 1'b1; wa = {i_q, j_q};
        wd = sat32($signed({{32{tmp_q[31]}}, tmp_q}) -
                   ((prod_q < 0) ? -((-prod_q) >>> 16) : (prod_q >>> 16)));
        if ({1'b0, j_q} == cols_i - 1'b1) begin
          st_d = BK_FACR; ph_d = '0;
          if ({1'b0, i_q} == rows_i - 1'b1) begin
            if ({1'b0, k_q} == lim - 1'b1) begin
              i_d = '0; j_d = '0; st_d = BK_EMIT;
            end else begin
              k_d = k_q + 1'b1; st_d = BK_SRCH;
            end
          end else i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1; st_d = BK_ELR;
        end
      end
      BK_EMIT: begin
        ra = {i_q, j_q};
        if (!ov_q || pop) st_d = BK_EMITW;
      end
      BK_EMITW: begin
        ra = {i_q, j_q};
        if (!ov_d) begin
          ov_d = 1'b1;
          if ({1'b0, j_q} == cols_i - 1'b1) begin
            j_d = '0;
            if ({1'b0, i_q} == rows_i - 1'b1) st_d = BK_IDLE;
            else begin
              i_d = i_q + 1'b1; st_d = BK_EMIT;
            end
          end else begin
            j_d = j_q + 1'b1; st_d = BK_EMIT;
          end
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_EMITW && (!ov_q || pop)) begin
      ob_val_q <= rd_q;
      ob_r_q <= i_q;
      ob_c_q <= j_q;
      ob_s_q <= sing_q;
      ob_l_q <= ({1'b0, j_q} == cols_i - 1'b1) && ({1'b0, i_q} == rows_i - 1'b1);
    end
    k_q <= k_d; i_q <= i_d; j_q <= j_d; best_q <= best_d; bmag_q <= bmag_d;
    piv_q <= piv_d; fac_q <= fac_d; tmp_q <= tmp_d; kv_q <= kv_d; ph_q <= ph_d;
    prod_q <= prod_d; sing_q <= sing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) ov_q && !pop |=> ov_q)
    else $error("result lost while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_o |-> st_q == BK_IDLE)
    else $error("queue drained outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) dstart |-> !dbusy)
    else $error("divider restarted while busy");

endmodule

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gjr_pkg::*;

  localparam int IdleLimit = 40000;
  localparam int QOne = 65536;

  typedef enum int {
    FILL_FIXED,
    FILL_IDENT,
    FILL_RAND,
    FILL_TINY
  } fill_e;

  typedef struct {
    int rows_w;
    int cols_w;
    int thr_w;
    fill_e fill;
    logic [31:0] fixed_val;
    bit early;
    bit extra;
    bit typed;
    logic [31:0] typed_val;
    bit typed_sing;
  } plan_row_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0] row;
    logic [2:0] col;
    logic sing;
    logic last;
  } cell_result_t;

  logic clk;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [31:0] element_value_i = '0;
  logic is_last_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [31:0] result_value_o;
  logic [2:0] row_index_o;
  logic [2:0] col_index_o;
  logic singular_o;
  logic last_out_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gauss_jordan_reduce_unit u_dut (
    .clk_i(clk), .rst_ni(rst_ni), .push(push), .full(full),
    .element_value_i(element_value_i), .is_last_i(is_last_i),
    .empty(empty), .pop(pop), .result_value_o(result_value_o),
    .row_index_o(row_index_o), .col_index_o(col_index_o),
    .singular_o(singular_o), .last_out_o(last_out_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic signed [31:0] grid_model [MaxDim*MaxDim];
  bit grid_written [MaxDim*MaxDim];
  logic [3:0] rows_reg = 4'd8;
  logic [3:0] cols_reg = 4'd8;
  logic [15:0] thr_reg = 16'd1;
  int load_cnt;
  cell_result_t pending_cells[$];
  bit typed_armed;
  logic [31:0] typed_value;
  bit typed_singular;
  int mismatches, items_sent, matrices_done, singular_seen, cells_checked, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int dim_of(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return MaxDim;
    return int'(v);
  endfunction

  function automatic int slot(int r, int c);
    return (r % MaxDim) * MaxDim + (c % MaxDim);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint magnitude(logic signed [31:0] v);
    longint w;
    w = longint'(v);
    return (w < 0) ? -w : w;
  endfunction

  function automatic bit eliminate(int rows, int cols);
    int lim, best;
    longint bm, m, p, f, prod;
    logic signed [31:0] t;
    bit tw;
    lim = (rows < cols) ? rows : cols;
    for (int k = 0; k < lim; k++) begin
      best = k;
      bm = magnitude(grid_model[slot(k, k)]);
      for (int i = k + 1; i < rows; i++) begin
        m = magnitude(grid_model[slot(i, k)]);
        if (m > bm) begin
          bm = m;
          best = i;
        end
      end
      if (bm == 0 || bm < longint'(thr_reg)) return 1'b1;
      if (best != k) begin
        for (int j = 0; j < MaxDim; j++) begin
          t = grid_model[slot(k, j)];
          grid_model[slot(k, j)] = grid_model[slot(best, j)];
          grid_model[slot(best, j)] = t;
          tw = grid_written[slot(k, j)];
          grid_written[slot(k, j)] = grid_written[slot(best, j)];
          grid_written[slot(best, j)] = tw;
        end
      end
      p = longint'(grid_model[slot(k, k)]);
      for (int j = k; j < cols; j++)
        grid_model[slot(k, j)] = clip32((longint'(grid_model[slot(k, j)]) * QOne) / p);
      for (int i = 0; i < rows; i++) begin
        if (i != k) begin
          f = longint'(grid_model[slot(i, k)]);
          for (int j = k; j < cols; j++) begin
            prod = (longint'(grid_model[slot(k, j)]) * f) / QOne;
            grid_model[slot(i, j)] = clip32(longint'(grid_model[slot(i, j)]) - prod);
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void absorb_element(logic [31:0] v, bit last);
    int rows, cols, n;
    bit sing;
    cell_result_t res;
    rows = dim_of(rows_reg);
    cols = dim_of(cols_reg);
    if (load_cnt < rows * cols) begin
      grid_model[slot(load_cnt / cols, load_cnt % cols)] = v;
      grid_written[slot(load_cnt / cols, load_cnt % cols)] = 1'b1;
      load_cnt++;
    end
    if (!last) return;
    sing = eliminate(rows, cols);
    if (sing) singular_seen++;
    n = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        res.value = grid_model[slot(r, c)];
        res.row = r[2:0];
        res.col = c[2:0];
        res.sing = sing;
        res.last = (n + 1 == rows * cols);
        if (typed_armed && n == 0) begin
          res.value = typed_value;
          res.sing = typed_singular;
        end
        pending_cells.push_back(res);
        n++;
      end
    end
    typed_armed = 1'b0;
    load_cnt = 0;
    matrices_done++;
  endfunction

  function automatic bit region_loaded();
    for (int r = 0; r < dim_of(rows_reg); r++)
      for (int c = 0; c < dim_of(cols_reg); c++)
        if (!grid_written[slot(r, c)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] make_value(fill_e fill, logic [31:0] fixed, int r, int c);
    int pick;
    case (fill)
      FILL_FIXED: return fixed;
      FILL_IDENT: return (r == c) ? 32'h0001_0000 : 32'h0;
      FILL_TINY: return $urandom_range(0, 3) - 1;
      default: begin
        pick = $urandom_range(0, 99);
        if (pick < 45) return ($urandom_range(0, 8) - 4) * QOne + $urandom_range(0, 65535);
        if (pick < 70) return $urandom;
        if (pick < 80) return 32'h0;
        if (pick < 85) return 32'h7fff_ffff;
        if (pick < 90) return 32'h8000_0000;
        return $urandom_range(0, 3);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
    mismatches++;
  endtask

  task automatic send_element(logic [31:0] v, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    element_value_i <= v;
    is_last_i <= last;
    do @(posedge clk); while (full);
    absorb_element(v, last);
    items_sent++;
  endtask

  task automatic apb_write(logic [1:0] index, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (index == RegRows) rows_reg = data[3:0];
    else if (index == RegCols) cols_reg = data[3:0];
    else if (index == RegThr) thr_reg = data[15:0];
  endtask

  task automatic configure(int rows_w, int cols_w, int thr_w);
    push <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    apb_write(RegRows, rows_w);
    apb_write(RegCols, cols_w);
    apb_write(RegThr, thr_w);
  endtask

  task automatic send_matrix(fill_e fill, logic [31:0] fixed, bit early, bit extra);
    int rows, cols, total, count, spare;
    rows = dim_of(rows_reg);
    cols = dim_of(cols_reg);
    total = rows * cols;
    count = total;
    if (early && total > 1 && region_loaded()) count = $urandom_range(1, total - 1);
    spare = (extra && count == total) ? $urandom_range(1, 3) : 0;
    for (int n = 0; n < count + spare; n++)
      send_element(make_value(fill, fixed, n / cols, n % cols), n == count + spare - 1);
  endtask

  plan_row_t plan [8] = '{
    '{1, 1, 1, FILL_FIXED, 32'h0002_0000, 0, 0, 1, 32'h0001_0000, 0},
    '{1, 1, 0, FILL_FIXED, 32'h0000_0000, 0, 0, 1, 32'h0000_0000, 1},
    '{1, 1, 1, FILL_FIXED, 32'h8000_0000, 0, 0, 1, 32'h0001_0000, 0},
    '{1, 1, 65535, FILL_FIXED, 32'hffff_fffe, 0, 0, 1, 32'hffff_fffe, 1},
    '{2, 2, 1, FILL_IDENT, 32'h0, 0, 1, 0, 32'h0, 0},
    '{2, 3, 1, FILL_RAND, 32'h0, 0, 0, 0, 32'h0, 0},
    '{0, 15, 1, FILL_RAND, 32'h0, 0, 0, 0, 32'h0, 0},
    '{0, 15, 1, FILL_RAND, 32'h0, 1, 0, 0, 32'h0, 0}
  };

  initial begin
    int r, rw, cw, tw;
    fill_e fill;
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk);
    apb_write(2'd3, 32'h5);
    foreach (plan[i]) begin
      configure(plan[i].rows_w, plan[i].cols_w, plan[i].thr_w);
      typed_armed = plan[i].typed;
      typed_value = plan[i].typed_val;
      typed_singular = plan[i].typed_sing;
      send_matrix(plan[i].fill, plan[i].fixed_val, plan[i].early, plan[i].extra);
    end
    while (items_sent < 220) begin
      if ($urandom_range(0, 99) < 35) begin
        r = $urandom_range(0, 99);
        rw = (r < 85) ? $urandom_range(1, 4) : (r < 93 ? 8 : $urandom_range(0, 15));
        r = $urandom_range(0, 99);
        cw = (r < 85) ? $urandom_range(1, 4) : (r < 93 ? 8 : $urandom_range(0, 15));
        r = $urandom_range(0, 99);
        tw = (r < 60) ? $urandom_range(0, 2) : (r < 80 ? 65535 : $urandom_range(0, 65535));
        configure(rw, cw, tw);
      end
      r = $urandom_range(0, 99);
      fill = (r < 85) ? FILL_RAND : (r < 93 ? FILL_TINY : FILL_IDENT);
      send_matrix(fill, 32'h0, $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 8);
    end
    push <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d elements in %0d matrices, %0d of them singular.",
             items_sent, matrices_done, singular_seen);
    $display("Checked %0d result transactions field by field.", cells_checked);
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("[gauss_jordan_reduce_unit] OK");
    end else begin
      $display("[gauss_jordan_reduce_unit] ERROR");
    end
    $finish;
  end

  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 20);
      pop <= 1'b1;
      repeat (run) @(posedge clk);
      run = pick_gap();
      if (run > 0) begin
        pop <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("unexpected transaction", 32'h0, result_value_o);
      end else begin
        want = pending_cells.pop_front();
        cells_checked++;
        if (result_value_o !== want.value) report_mismatch("value", want.value, result_value_o);
        if (row_index_o !== want.row)
          report_mismatch("row", 32'(want.row), 32'(row_index_o));
        if (col_index_o !== want.col)
          report_mismatch("col", 32'(want.col), 32'(col_index_o));
        if (singular_o !== want.sing)
          report_mismatch("singular", 32'(want.sing), 32'(singular_o));
        if (last_out_o !== want.last)
          report_mismatch("last", 32'(want.last), 32'(last_out_o));
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || psel || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("timeout: no transaction for %0d cycles", IdleLimit);
      $display("[gauss_jordan_reduce_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
